FILE: design/ptt_pkg.sv
// shared types and constants for the page translation table
// no dependencies; used by every module of the block
package ptt_pkg;

  // table geometry
  localparam int MaxPages = 16;
  localparam int IdxW     = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int CntW     = $clog2(MaxPages + 1);

  // address layout for 4 KiB pages
  localparam int OffW    = 12;
  localparam int PageW   = 20;
  localparam int AddrW   = 32;
  localparam int CfgW    = 5;
  localparam int AliasW  = 2;

  localparam logic [AddrW-1:0] BusAlias      = 32'hC000_0000;
  localparam logic [CfgW-1:0]  PagesResetVal = 5'd16;

  // command codes
  typedef enum logic [2:0] {
    CmdLoad      = 3'd0,
    CmdVirtPhys  = 3'd1,
    CmdPhysVirt  = 3'd2,
    CmdOffVirt   = 3'd3,
    CmdOffPhys   = 3'd4,
    CmdVirtOff   = 3'd5
  } cmd_e;

  // input word
  typedef struct packed {
    logic [2:0]       cmd;
    logic [3:0]       entry_index;
    logic [PageW-1:0] virt_page_in;
    logic [PageW-1:0] phys_page_in;
    logic [AddrW-1:0] address;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [AddrW-1:0] address_out;
    logic             hit;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new word, write the table on a load command
    logic step;    // examine the next entry
    logic res_we;  // capture the result of this step
    logic out_we;  // move the held result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;    // the current step finishes the word
  } dp_status_t;

endpackage

FILE: design/page_translation_table_core.sv
// top level of the page translation table
// depends on ptt_pkg, ptt_ctrl and ptt_datapath
//
//  channel  direction  handshake          word
//  in       input      in_valid/in_stall  ptt_pkg::in_word_t
//  out      output     out_valid/out_stall ptt_pkg::out_word_t
//  cfg      input      cfg_valid/cfg_ready pages_in_use, 5 bits
//
// load and offset commands need no search; searches compare one table entry
// per cycle until a match or the last page in use
// the result waits in an output register, so a new word is taken meanwhile
// reset clears the controller and sets pages_in_use to 16; table contents
// are undefined until loaded
// cfg_ready is always high; writes are expected only while the block is idle
module page_translation_table_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  ptt_pkg::in_word_t        in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output ptt_pkg::out_word_t       out_word_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ptt_pkg::CfgW-1:0] cfg_data_i
);

  ptt_pkg::ctrl_cmd_t  ctrl_cmd;
  ptt_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  // controller
  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  // datapath
  ptt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (ctrl_cmd),
    .status_o   (dp_status),
    .out_word_o (out_word_o)
  );

endmodule

FILE: design/ptt_ctrl.sv
// controller state machine for the page translation table
// depends on ptt_pkg
module ptt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ptt_pkg::dp_status_t status_i,
  output ptt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StPush
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // output slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o        = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.done) begin
          cmd_o.res_we = 1'b1;
          state_d      = StPush;
        end
      end
      StPush: begin
        if (slot_free) begin
          cmd_o.out_we = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/ptt_datapath.sv
// datapath of the page translation table: page stores, scan counter,
// match logic, result and output registers; depends on ptt_pkg
module ptt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptt_pkg::in_word_t             in_word_i,
  input  logic                          cfg_we_i,
  input  logic [ptt_pkg::CfgW-1:0]      cfg_data_i,
  input  ptt_pkg::ctrl_cmd_t            cmd_i,
  output ptt_pkg::dp_status_t           status_o,
  output ptt_pkg::out_word_t            out_word_o
);

  // page stores, written by load commands only
  logic [ptt_pkg::PageW-1:0] virt_store [ptt_pkg::MaxPages];
  logic [ptt_pkg::PageW-1:0] phys_store [ptt_pkg::MaxPages];

  ptt_pkg::in_word_t         req_q;
  ptt_pkg::out_word_t        res_q, res_d;
  ptt_pkg::out_word_t        out_q;
  logic [ptt_pkg::IdxW-1:0]  scan_q;
  logic [ptt_pkg::CfgW-1:0]  pages_q;

  logic [ptt_pkg::CntW-1:0]  pages_eff;
  logic [ptt_pkg::IdxW-1:0]  rd_idx;
  logic                      in_is_off;
  logic [ptt_pkg::PageW-1:0] virt_rd_q, phys_rd_q;
  logic [ptt_pkg::PageW-1:0] page_key, key_virt, key_phys;
  logic [ptt_pkg::OffW-1:0]  off;
  logic                      empty, last_entry, in_range, load_ok;
  logic                      match_virt, match_phys;
  logic                      done;

  // page count clamped to the table size
  assign pages_eff = (32'(pages_q) > 32'(ptt_pkg::MaxPages)) ?
                     ptt_pkg::CntW'(ptt_pkg::MaxPages) : ptt_pkg::CntW'(pages_q);
  assign empty      = (pages_eff == '0);
  assign last_entry = ((32'(scan_q) + 32'd1) == 32'(pages_eff));

  // address split
  assign off      = req_q.address[ptt_pkg::OffW-1:0];
  assign key_virt = req_q.address[ptt_pkg::AddrW-1:ptt_pkg::OffW];
  assign key_phys = {{ptt_pkg::AliasW{1'b0}},
                     req_q.address[ptt_pkg::AddrW-ptt_pkg::AliasW-1:ptt_pkg::OffW]};
  assign in_range = (32'(key_virt) < 32'(pages_eff));
  assign load_ok  = (32'(req_q.entry_index) < 32'(ptt_pkg::MaxPages));

  // single read port, registered in the cycle before the step that uses it: at the accept
  // edge offset commands fetch their entry and searches entry 0, then each
  // step fetches the entry after the current one
  assign in_is_off = (ptt_pkg::cmd_e'(in_word_i.cmd) == ptt_pkg::CmdOffVirt ||
                      ptt_pkg::cmd_e'(in_word_i.cmd) == ptt_pkg::CmdOffPhys);
  assign rd_idx = !cmd_i.load ? scan_q + ptt_pkg::IdxW'(1) :
                  in_is_off   ? in_word_i.address[ptt_pkg::OffW +: ptt_pkg::IdxW] :
                                ptt_pkg::IdxW'(0);

  // registered table read
  always_ff @(posedge clk_i) begin
    virt_rd_q <= virt_store[rd_idx];
    phys_rd_q <= phys_store[rd_idx];
  end

  assign page_key   = (ptt_pkg::cmd_e'(req_q.cmd) == ptt_pkg::CmdPhysVirt) ?
                      key_phys : key_virt;
  assign match_virt = (virt_rd_q == page_key);
  assign match_phys = (phys_rd_q == page_key);

  // outcome of the current step
  always_comb begin
    done  = 1'b1;
    res_d = '0;
    unique case (ptt_pkg::cmd_e'(req_q.cmd))
      ptt_pkg::CmdLoad: begin
        res_d.hit = load_ok;
      end
      ptt_pkg::CmdVirtPhys: begin
        if (!empty && match_virt) begin
          res_d.hit         = 1'b1;
          res_d.address_out = {phys_rd_q, off} | ptt_pkg::BusAlias;
        end else begin
          done = empty || last_entry;
        end
      end
      ptt_pkg::CmdPhysVirt: begin
        if (!empty && match_phys) begin
          res_d.hit         = 1'b1;
          res_d.address_out = {virt_rd_q, off};
        end else begin
          done = empty || last_entry;
        end
      end
      ptt_pkg::CmdOffVirt: begin
        if (in_range) begin
          res_d.hit         = 1'b1;
          res_d.address_out = {virt_rd_q, off};
        end
      end
      ptt_pkg::CmdOffPhys: begin
        if (in_range) begin
          res_d.hit         = 1'b1;
          res_d.address_out = {phys_rd_q, off};
        end
      end
      ptt_pkg::CmdVirtOff: begin
        if (!empty && match_virt) begin
          res_d.hit         = 1'b1;
          res_d.address_out = {ptt_pkg::PageW'(scan_q), off};
        end else begin
          done = empty || last_entry;
        end
      end
      default: res_d = '0;
    endcase
  end

  assign status_o.done = done;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= ptt_pkg::PagesResetVal;
    end else if (cfg_we_i) begin
      pages_q <= cfg_data_i;
    end
  end

  // table write on an accepted load
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ptt_pkg::cmd_e'(in_word_i.cmd) == ptt_pkg::CmdLoad &&
        32'(in_word_i.entry_index) < 32'(ptt_pkg::MaxPages)) begin
      virt_store[ptt_pkg::IdxW'(in_word_i.entry_index)] <= in_word_i.virt_page_in;
      phys_store[ptt_pkg::IdxW'(in_word_i.entry_index)] <= in_word_i.phys_page_in;
    end
  end

  // request, scan counter, result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_word_i;
      scan_q <= '0;
    end else if (cmd_i.step) begin
      scan_q <= scan_q + ptt_pkg::IdxW'(1);
    end
    if (cmd_i.res_we) begin
      res_q <= res_d;
    end
    if (cmd_i.out_we) begin
      out_q <= res_q;
    end
  end

  assign out_word_o = out_q;

endmodule
